>>> hdl/ipmr_pkg.sv
package ipmr_pkg;

   localparam int TableEntriesDefault = 256;
   localparam int EntryIndexWidth     = 8;
   localparam int ByteCountWidth      = 6;

   localparam logic [ByteCountWidth-1:0] CountMax        = 6'd63;
   localparam logic [ByteCountWidth-1:0] EtherTypeOffset = 6'd12;
   localparam logic [ByteCountWidth-1:0] SrcIpOffset     = 6'd26;
   localparam logic [ByteCountWidth-1:0] DstIpOffset     = 6'd30;
   localparam logic [ByteCountWidth-1:0] MinIpv4Bytes    = 6'd34;
   localparam logic [15:0]               EtherTypeIpv4   = 16'h0800;

   localparam logic OpFrameByte  = 1'b0;
   localparam logic OpTableWrite = 1'b1;

   localparam logic VerdictPass     = 1'b0;
   localparam logic VerdictRedirect = 1'b1;

   typedef struct packed {
      logic                       opcode;
      logic [7:0]                 frame_byte;
      logic                       frame_last;
      logic [EntryIndexWidth-1:0] entry_index;
      logic                       entry_valid;
      logic [31:0]                entry_src_ip;
      logic [31:0]                entry_dst_ip;
      logic [15:0]                entry_port;
      logic [47:0]                entry_dest_mac;
      logic [47:0]                entry_src_mac;
   } req_type;

   typedef struct packed {
      logic        verdict;
      logic [15:0] out_port;
      logic [47:0] new_dest_mac;
      logic [47:0] new_src_mac;
   } rsp_type;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] port;
      logic [47:0] dest_mac;
      logic [47:0] src_mac;
   } entry_data_type;

   typedef struct packed {
      logic           valid;
      entry_data_type data;
   } entry_type;

   typedef struct packed {
      logic                       en;
      logic [EntryIndexWidth-1:0] index;
      entry_type                  entry;
   } table_write_type;

   typedef struct packed {
      logic        eligible;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
   } hdr_type;

endpackage

>>> hdl/ipv4_pair_match_mac_rewrite_redirect_top.sv
// IPv4 address-pair redirect with MAC rewrite.
// req channel: one item per transfer. Opcode frame byte carries the next byte of an
// Ethernet frame and a last-byte flag; opcode table write installs or removes one
// flow entry (slots at or above TABLE_ENTRIES are ignored).
// rsp channel: one verdict per frame, given after the frame's last byte: pass with zero
// fields, or redirect with the entry's port and replacement MACs.
// Frame bytes and table writes are taken one per cycle while req_stall is low. The
// last byte of a frame that is IPv4 and at least 34 bytes long starts a search: the
// table entries rotate through the cell chain one position a cycle, and the head
// cell compares each against the address pair, so the search sees every entry once.
// The verdict is loaded into the output register from the DONE state, after the
// search, or directly for frames that cannot match; req_stall is high meanwhile.
// When rsp_stall holds a verdict in the output register, later bytes are still
// taken, and the next verdict waits with req_stall high until the register frees.
// Reset clears all valid bits and the header capture at once; no clearing pass.
module ipv4_pair_match_mac_rewrite_redirect_top
   import ipmr_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CntWidth = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [CntWidth-1:0] CntLast = CntWidth'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {IDLE, SCAN, DONE} state_type;

   state_type           state_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic                found_ff;
   rsp_type             result_ff;
   logic [31:0]         key_src_ff;
   logic [31:0]         key_dst_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic            req_accept;
   logic            byte_en;
   logic            frame_end;
   table_write_type wr;
   hdr_type         hdr;
   logic            shift_en;
   logic            head_hit;
   logic            out_free;
   logic            load_rsp;
   entry_type       cell_entry [TABLE_ENTRIES];

   assign req_stall  = (state_ff != IDLE);
   assign req_accept = req_valid && !req_stall;
   assign byte_en    = req_accept && (req_data.opcode == OpFrameByte);
   assign frame_end  = byte_en && req_data.frame_last;
   assign shift_en   = (state_ff == SCAN);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load_rsp   = (state_ff == DONE) && out_free;

   assign wr.en                  = req_accept && (req_data.opcode == OpTableWrite);
   assign wr.index               = req_data.entry_index;
   assign wr.entry.valid         = req_data.entry_valid;
   assign wr.entry.data.src_ip   = req_data.entry_src_ip;
   assign wr.entry.data.dst_ip   = req_data.entry_dst_ip;
   assign wr.entry.data.port     = req_data.entry_port;
   assign wr.entry.data.dest_mac = req_data.entry_dest_mac;
   assign wr.entry.data.src_mac  = req_data.entry_src_mac;

   ipmr_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .byte_en    (byte_en),
      .frame_byte (req_data.frame_byte),
      .frame_last (req_data.frame_last),
      .hdr        (hdr)
   );

   // entries rotate toward cell 0 while searching and are home again after a full turn
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      ipmr_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr         (wr),
         .shift_en   (shift_en),
         .next_entry (cell_entry[(i + 1) % TABLE_ENTRIES]),
         .entry      (cell_entry[i])
      );
   end

   assign head_hit = cell_entry[0].valid
                     && (cell_entry[0].data.src_ip == key_src_ff)
                     && (cell_entry[0].data.dst_ip == key_dst_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= load_rsp || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            IDLE: begin
               if (frame_end) begin
                  found_ff   <= 1'b0;
                  result_ff  <= '0;
                  key_src_ff <= hdr.src_ip;
                  key_dst_ff <= hdr.dst_ip;
                  cnt_ff     <= '0;
                  state_ff   <= hdr.eligible ? SCAN : DONE;
               end
            end
            SCAN: begin
               if (!found_ff && head_hit) begin
                  found_ff                <= 1'b1;
                  result_ff.verdict      <= VerdictRedirect;
                  result_ff.out_port     <= cell_entry[0].data.port;
                  result_ff.new_dest_mac <= cell_entry[0].data.dest_mac;
                  result_ff.new_src_mac  <= cell_entry[0].data.src_mac;
               end
               if (cnt_ff == CntLast) begin
                  cnt_ff   <= '0;
                  state_ff <= DONE;
               end else begin
                  cnt_ff <= cnt_ff + CntWidth'(1);
               end
            end
            DONE: begin
               if (out_free) begin
                  rsp_data_ff  <= result_ff;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rotation_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff != SCAN) |-> (cnt_ff == '0))
      else $error("search counter not at home outside a search");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN && cnt_ff == CntLast) |=> (state_ff == DONE))
      else $error("search did not finish after a full rotation");

   a_pass_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.verdict == VerdictPass) |->
         (rsp_data.out_port == '0 && rsp_data.new_dest_mac == '0
          && rsp_data.new_src_mac == '0))
      else $error("pass verdict with nonzero fields");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == DONE))
      else $error("verdict loaded outside the done state");
`endif

endmodule

>>> hdl/ipmr_parse.sv
module ipmr_parse
   import ipmr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_en,
   input  logic [7:0] frame_byte,
   input  logic       frame_last,
   output hdr_type    hdr
);

   logic [ByteCountWidth-1:0] count_ff, count_in;
   logic [15:0]               ether_ff, ether_in;
   logic [31:0]               src_ff, src_in;
   logic [31:0]               dst_ff, dst_in;

   always_comb begin
      count_in = count_ff;
      ether_in = ether_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      if (count_ff == EtherTypeOffset || count_ff == EtherTypeOffset + 6'd1) begin
         ether_in = {ether_ff[7:0], frame_byte};
      end else if (count_ff >= SrcIpOffset && count_ff < DstIpOffset) begin
         src_in = {src_ff[23:0], frame_byte};
      end else if (count_ff >= DstIpOffset && count_ff < MinIpv4Bytes) begin
         dst_in = {dst_ff[23:0], frame_byte};
      end
      if (count_ff != CountMax) begin
         count_in = count_ff + 6'd1;
      end
      hdr.eligible = (count_in >= MinIpv4Bytes) && (ether_in == EtherTypeIpv4);
      hdr.src_ip   = src_in;
      hdr.dst_ip   = dst_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ether_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
      end else if (byte_en) begin
         if (frame_last) begin
            count_ff <= '0;
            ether_ff <= '0;
            src_ff   <= '0;
            dst_ff   <= '0;
         end else begin
            count_ff <= count_in;
            ether_ff <= ether_in;
            src_ff   <= src_in;
            dst_ff   <= dst_in;
         end
      end
   end

endmodule

>>> hdl/ipmr_cell.sv
module ipmr_cell
   import ipmr_pkg::*;
#(
   parameter int CELL_INDEX = 0
)
(
   input  logic            clock,
   input  logic            reset,
   input  table_write_type wr,
   input  logic            shift_en,
   input  entry_type       next_entry,
   output entry_type       entry
);

   logic           valid_ff;
   entry_data_type data_ff;
   logic           sel;

   assign sel   = wr.en && ({{(32-EntryIndexWidth){1'b0}}, wr.index} == 32'(CELL_INDEX));
   assign entry = '{valid: valid_ff, data: data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel) begin
         valid_ff <= wr.entry.valid;
      end else if (shift_en) begin
         valid_ff <= next_entry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         data_ff <= wr.entry.data;
      end else if (shift_en) begin
         data_ff <= next_entry.data;
      end
   end

endmodule
